/* hw/rtl/read_length_quality_stats_macros.svh */
// Assertion macros shared by the read statistics RTL.
`ifndef READ_LENGTH_QUALITY_STATS_MACROS_SVH
`define READ_LENGTH_QUALITY_STATS_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define RLQS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Property that must hold in the cycle after its trigger.
`define RLQS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rlqs_pkg.sv */
// Types, constants and helpers for the read length and quality statistics block.
package rlqs_pkg;

    localparam int CNT_W             = 32;
    localparam int LEN_W             = 32;
    localparam int TOTAL_W           = 48;
    localparam int QFIX_W            = 10;
    localparam int QFRAC_W           = 4;
    localparam int QINT_W            = 6;
    localparam int IDX_W             = 12;
    localparam int LENGTH_BINS_DEF   = 4096;
    localparam int QUALITY_BINS_DEF  = 64;
    localparam int S_TDATA_W         = 56;
    localparam int S_TUSER_W         = 3;
    localparam int M_TDATA_W         = 160;

    typedef enum logic [1:0] {
        OP_ACC      = 2'd0,
        OP_SUMMARY  = 2'd1,
        OP_LEN_BIN  = 2'd2,
        OP_QUAL_BIN = 2'd3
    } rlqs_op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } rlqs_state_t;

    // One record applied to the bank summary registers.
    typedef struct packed {
        logic              upd;
        logic              bank;
        logic [LEN_W-1:0]  len;
        logic [QINT_W-1:0] q;
    } rlqs_upd_t;

    typedef struct packed {
        logic [CNT_W-1:0]   reads_count;
        logic [TOTAL_W-1:0] bases_total;
        logic [LEN_W-1:0]   longest_length;
        logic [QINT_W-1:0]  min_quality;
        logic [QINT_W-1:0]  max_quality;
        logic               quality_seen;
    } rlqs_summary_t;

    // Result transfer layout, first member in the highest bits.
    typedef struct packed {
        logic [2:0]         pad;
        logic [CNT_W-1:0]   bin_count;
        logic               quality_seen;
        logic [QINT_W-1:0]  max_quality;
        logic [QINT_W-1:0]  min_quality;
        logic [LEN_W-1:0]   longest_length;
        logic [TOTAL_W-1:0] bases_total;
        logic [CNT_W-1:0]   reads_count;
    } rlqs_result_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

/* hw/rtl/rlqs_hist_ram.sv */
// Histogram bin memory: one write port, one read port with registered data.
module rlqs_hist_ram #(
    parameter int DEPTH = 2 * rlqs_pkg::LENGTH_BINS_DEF
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [rlqs_pkg::CNT_W-1:0] wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [rlqs_pkg::CNT_W-1:0] rdata
);
    import rlqs_pkg::*;

    logic [CNT_W-1:0] mem [DEPTH];
    logic [CNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/rlqs_bank_stats.sv */
// Per-bank summary registers: read count, base total, longest read, quality range.
module rlqs_bank_stats (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rlqs_pkg::rlqs_upd_t     upd,
    input  logic                    sel_bank,
    output rlqs_pkg::rlqs_summary_t summary
);
    import rlqs_pkg::*;

    logic [CNT_W-1:0]   count_reg   [2];
    logic [TOTAL_W-1:0] total_reg   [2];
    logic [LEN_W-1:0]   longest_reg [2];
    logic [QINT_W-1:0]  low_reg     [2];
    logic [QINT_W-1:0]  high_reg    [2];
    logic               seen_reg    [2];

    logic [CNT_W-1:0]   count_next;
    logic [TOTAL_W-1:0] total_next;
    logic [LEN_W-1:0]   longest_next;
    logic [QINT_W-1:0]  low_next;
    logic [QINT_W-1:0]  high_next;
    logic [TOTAL_W:0]   sum;

    always_comb
    begin
        count_next   = sat_inc(count_reg[upd.bank]);
        sum          = {1'b0, total_reg[upd.bank]} + (TOTAL_W+1)'(upd.len);
        total_next   = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
        longest_next = (upd.len > longest_reg[upd.bank]) ? upd.len : longest_reg[upd.bank];
        low_next     = (!seen_reg[upd.bank] || upd.q < low_reg[upd.bank]) ?
                       upd.q : low_reg[upd.bank];
        high_next    = (upd.q > high_reg[upd.bank]) ? upd.q : high_reg[upd.bank];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < 2; b++)
            begin
                count_reg[b]   <= '0;
                total_reg[b]   <= '0;
                longest_reg[b] <= '0;
                low_reg[b]     <= '0;
                high_reg[b]    <= '0;
                seen_reg[b]    <= 1'b0;
            end
        end
        else if (upd.upd)
        begin
            count_reg[upd.bank]   <= count_next;
            total_reg[upd.bank]   <= total_next;
            longest_reg[upd.bank] <= longest_next;
            low_reg[upd.bank]     <= low_next;
            high_reg[upd.bank]    <= high_next;
            seen_reg[upd.bank]    <= 1'b1;
        end
    end

    assign summary.reads_count    = count_reg[sel_bank];
    assign summary.bases_total    = total_reg[sel_bank];
    assign summary.longest_length = longest_reg[sel_bank];
    assign summary.min_quality    = low_reg[sel_bank];
    assign summary.max_quality    = high_reg[sel_bank];
    assign summary.quality_seen   = seen_reg[sel_bank];

endmodule

/* hw/rtl/read_length_quality_stats.sv */
// Read length and quality statistics: two banks (passed, failed) of counters and
// histograms. A transfer is accepted in the idle state, which reads the length and
// quality histogram memories; the execute state then writes the incremented bins
// back (accumulate) or loads the result register (reads), holding a read there
// until the result register frees up. A new transfer is taken while a result waits.
// After reset a clearing pass zeroes both histogram memories before the first transfer is accepted.
`include "read_length_quality_stats_macros.svh"

module read_length_quality_stats #(
    parameter int LENGTH_BINS  = rlqs_pkg::LENGTH_BINS_DEF,
    parameter int QUALITY_BINS = rlqs_pkg::QUALITY_BINS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // read_length[31:0], quality_fixed[41:32], bin_index[53:42], zero pad
    input  logic [rlqs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // opcode[1:0], passed[2]
    input  logic [rlqs_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // reads_count[31:0], bases_total[79:32], longest_length[111:80],
    // min_quality[117:112], max_quality[123:118], quality_seen[124],
    // bin_count[156:125], zero pad
    output logic [rlqs_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import rlqs_pkg::*;

    localparam int LDEPTH    = 2 * LENGTH_BINS;
    localparam int QDEPTH    = 2 * QUALITY_BINS;
    localparam int LADDR_W   = $clog2(LDEPTH);
    localparam int QADDR_W   = $clog2(QDEPTH);
    localparam int LBIN_W    = $clog2(LENGTH_BINS);
    localparam int QBIN_W    = $clog2(QUALITY_BINS);
    localparam int CLR_DEPTH = (LDEPTH > QDEPTH) ? LDEPTH : QDEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    rlqs_state_t state_reg, state_next;
    logic [CLR_W-1:0] clr_idx_reg, clr_idx_next;

    // Accepted transfer.
    rlqs_op_t           op_reg;
    logic               bank_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [QINT_W-1:0]  q_reg;
    logic [LADDR_W-1:0] laddr_reg;
    logic [QADDR_W-1:0] qaddr_reg;
    logic               lok_reg;
    logic               qok_reg;

    rlqs_result_t result_reg, result_next;
    logic         out_valid_reg, out_valid_next;

    logic               in_accept;
    rlqs_op_t           in_op;
    logic               in_bank;
    logic [LEN_W-1:0]   in_len;
    logic [QINT_W-1:0]  in_q;
    logic [IDX_W-1:0]   in_idx;
    logic [LBIN_W-1:0]  lbin;
    logic [QBIN_W-1:0]  qbin;
    logic [LADDR_W-1:0] laddr;
    logic [QADDR_W-1:0] qaddr;

    logic               lwe, qwe, out_load;
    logic [LADDR_W-1:0] lwaddr;
    logic [QADDR_W-1:0] qwaddr;
    logic [CNT_W-1:0]   lwdata, qwdata, lrdata, qrdata;

    rlqs_upd_t     upd;
    rlqs_summary_t summary;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_op     = rlqs_op_t'(s_axis_tuser[1:0]);
    assign in_bank   = s_axis_tuser[2];
    assign in_len    = s_axis_tdata[LEN_W-1:0];
    assign in_q      = s_axis_tdata[LEN_W+QFIX_W-1:LEN_W+QFRAC_W];
    assign in_idx    = s_axis_tdata[LEN_W+QFIX_W+IDX_W-1:LEN_W+QFIX_W];

    // Bin selection: accumulate clamps into the last bin, reads use bin_index.
    always_comb
    begin
        if (in_op == OP_ACC)
        begin
            lbin = (in_len < 32'(LENGTH_BINS - 1)) ? LBIN_W'(in_len) : LBIN_W'(LENGTH_BINS - 1);
            qbin = (9'(in_q) < 9'(QUALITY_BINS - 1)) ? QBIN_W'(in_q) : QBIN_W'(QUALITY_BINS - 1);
        end
        else
        begin
            lbin = LBIN_W'(in_idx);
            qbin = QBIN_W'(in_idx);
        end
        laddr = LADDR_W'(lbin) + (in_bank ? LADDR_W'(LENGTH_BINS) : LADDR_W'(0));
        qaddr = QADDR_W'(qbin) + (in_bank ? QADDR_W'(QUALITY_BINS) : QADDR_W'(0));
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= in_op;
            bank_reg  <= in_bank;
            len_reg   <= in_len;
            q_reg     <= in_q;
            laddr_reg <= laddr;
            qaddr_reg <= qaddr;
            lok_reg   <= 32'(in_idx) < 32'(LENGTH_BINS);
            qok_reg   <= 32'(in_idx) < 32'(QUALITY_BINS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        s_axis_tready = 1'b0;
        lwe           = 1'b0;
        qwe           = 1'b0;
        lwaddr        = laddr_reg;
        qwaddr        = qaddr_reg;
        lwdata        = sat_inc(lrdata);
        qwdata        = sat_inc(qrdata);
        out_load      = 1'b0;
        upd.upd       = 1'b0;
        upd.bank      = bank_reg;
        upd.len       = len_reg;
        upd.q         = q_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                lwe    = 32'(clr_idx_reg) < 32'(LDEPTH);
                qwe    = 32'(clr_idx_reg) < 32'(QDEPTH);
                lwaddr = LADDR_W'(clr_idx_reg);
                qwaddr = QADDR_W'(clr_idx_reg);
                lwdata = '0;
                qwdata = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (32'(clr_idx_reg) == 32'(CLR_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (op_reg == OP_ACC)
                begin
                    lwe        = 1'b1;
                    qwe        = 1'b1;
                    upd.upd    = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || m_axis_tready)
                begin
                    // Hold in this state until the result register frees up.
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_next = '0;
        case (op_reg)
            OP_SUMMARY:
            begin
                result_next.reads_count    = summary.reads_count;
                result_next.bases_total    = summary.bases_total;
                result_next.longest_length = summary.longest_length;
                result_next.min_quality    = summary.min_quality;
                result_next.max_quality    = summary.max_quality;
                result_next.quality_seen   = summary.quality_seen;
            end
            OP_LEN_BIN:  result_next.bin_count = lok_reg ? lrdata : '0;
            OP_QUAL_BIN: result_next.bin_count = qok_reg ? qrdata : '0;
            default:     result_next = '0;
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
    assign m_axis_tvalid  = out_valid_reg;
    assign m_axis_tdata   = result_reg;

    rlqs_hist_ram #(
        .DEPTH (LDEPTH)
    ) u_len_ram (
        .clk   (clk),
        .we    (lwe),
        .waddr (lwaddr),
        .wdata (lwdata),
        .re    (in_accept),
        .raddr (laddr),
        .rdata (lrdata)
    );

    rlqs_hist_ram #(
        .DEPTH (QDEPTH)
    ) u_qual_ram (
        .clk   (clk),
        .we    (qwe),
        .waddr (qwaddr),
        .wdata (qwdata),
        .re    (in_accept),
        .raddr (qaddr),
        .rdata (qrdata)
    );

    rlqs_bank_stats u_bank_stats (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (upd),
        .sel_bank (bank_reg),
        .summary  (summary)
    );

    `RLQS_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, state_reg == ST_CLEAR, !s_axis_tready, "transfer accepted during clearing pass")
    `RLQS_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, in_accept, state_reg == ST_EXEC, "accepted transfer did not start execution")
    `RLQS_ASSERT_NEXT(a_acc_one_cycle, clk, rst_n, state_reg == ST_EXEC && op_reg == OP_ACC, state_reg == ST_IDLE && !out_load, "accumulate did not retire in one cycle")
    `RLQS_ASSERT_NEXT(a_summary_no_bin, clk, rst_n, out_load && op_reg == OP_SUMMARY, m_axis_tvalid && result_reg.bin_count == '0, "summary result carries a bin count")

endmodule

/* test/tb.sv */
// Testbench for the read length and quality statistics block: directed and random streams checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import rlqs_pkg::*;

    localparam int IDLE_LIMIT   = 40000;   // longer than the clearing pass after reset
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int LONG_RECORDS = 64;      // max-length reads piled into one bank
    localparam int REPORT_MAX   = 100;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Per-bank statistics as the block should hold them
    logic [CNT_W-1:0]   bank_reads   [2];
    logic [TOTAL_W-1:0] bank_bases   [2];
    logic [LEN_W-1:0]   bank_longest [2];
    logic [QINT_W-1:0]  bank_qmin    [2];
    logic [QINT_W-1:0]  bank_qmax    [2];
    logic               bank_qseen   [2];
    logic [CNT_W-1:0]   length_bins  [2][LENGTH_BINS_DEF];
    logic [CNT_W-1:0]   quality_bins [2][QUALITY_BINS_DEF];

    rlqs_result_t      pending_results[$];
    int                error_count     = 0;
    int                send_idle_pct   = 0;
    int                recv_stall_pct  = 0;
    int                hold_off_cycles = 0;
    logic [IDX_W-1:0]  last_length_bin = '0;
    logic [IDX_W-1:0]  last_quality    = '0;

    read_length_quality_stats i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic void clear_stats();
        for (int b = 0; b < 2; b++)
        begin
            bank_reads[b]   = '0;
            bank_bases[b]   = '0;
            bank_longest[b] = '0;
            bank_qmin[b]    = '0;
            bank_qmax[b]    = '0;
            bank_qseen[b]   = 1'b0;
            for (int i = 0; i < LENGTH_BINS_DEF; i++)
                length_bins[b][i] = '0;
            for (int i = 0; i < QUALITY_BINS_DEF; i++)
                quality_bins[b][i] = '0;
        end
    endfunction

    // Update the statistics for one accepted transfer, queue its result if it has one.
    function automatic void apply_record(rlqs_op_t op, logic bank, logic [LEN_W-1:0] len,
                                         logic [QFIX_W-1:0] qfix, logic [IDX_W-1:0] idx);
        logic [QINT_W-1:0]  q;
        logic [TOTAL_W:0]   sum;
        int                 lbin;
        int                 qbin;
        rlqs_result_t       res;
        q   = qfix[QFIX_W-1:QFRAC_W];
        res = '0;
        case (op)
            OP_ACC:
            begin
                bank_reads[bank] = bump_count(bank_reads[bank]);
                sum = bank_bases[bank] + len;
                bank_bases[bank] = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
                if (len > bank_longest[bank])
                    bank_longest[bank] = len;
                // long reads land in the last length bin
                lbin = (len < LENGTH_BINS_DEF - 1) ? int'(len) : LENGTH_BINS_DEF - 1;
                length_bins[bank][lbin] = bump_count(length_bins[bank][lbin]);
                qbin = (q < QUALITY_BINS_DEF - 1) ? int'(q) : QUALITY_BINS_DEF - 1;
                quality_bins[bank][qbin] = bump_count(quality_bins[bank][qbin]);
                if (!bank_qseen[bank] || q < bank_qmin[bank])
                    bank_qmin[bank] = q;
                if (q > bank_qmax[bank])
                    bank_qmax[bank] = q;
                bank_qseen[bank] = 1'b1;
                last_length_bin  = IDX_W'(lbin);
                last_quality     = IDX_W'(q);
            end
            OP_SUMMARY:
            begin
                res.reads_count    = bank_reads[bank];
                res.bases_total    = bank_bases[bank];
                res.longest_length = bank_longest[bank];
                res.min_quality    = bank_qmin[bank];
                res.max_quality    = bank_qmax[bank];
                res.quality_seen   = bank_qseen[bank];
            end
            OP_LEN_BIN:
            begin
                if (idx < LENGTH_BINS_DEF)
                    res.bin_count = length_bins[bank][idx];
            end
            default:
            begin
                if (idx < QUALITY_BINS_DEF)
                    res.bin_count = quality_bins[bank][idx];
            end
        endcase
        if (op != OP_ACC)
            pending_results.insert(pending_results.size(), res);
    endfunction

    task automatic report_mismatch(string what, logic [TOTAL_W-1:0] got,
                                   logic [TOTAL_W-1:0] want);
        error_count++;
        if (error_count <= REPORT_MAX)
            $display("ERROR at %0t: %s is 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic check_result(rlqs_result_t got);
        rlqs_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result with nothing outstanding, bin_count", got.bin_count, '0);
            return;
        end
        want = pending_results.pop_front();
        if (got.reads_count !== want.reads_count)
            report_mismatch("reads_count", got.reads_count, want.reads_count);
        if (got.bases_total !== want.bases_total)
            report_mismatch("bases_total", got.bases_total, want.bases_total);
        if (got.longest_length !== want.longest_length)
            report_mismatch("longest_length", got.longest_length, want.longest_length);
        if (got.min_quality !== want.min_quality)
            report_mismatch("min_quality", got.min_quality, want.min_quality);
        if (got.max_quality !== want.max_quality)
            report_mismatch("max_quality", got.max_quality, want.max_quality);
        if (got.quality_seen !== want.quality_seen)
            report_mismatch("quality_seen", got.quality_seen, want.quality_seen);
        if (got.bin_count !== want.bin_count)
            report_mismatch("bin_count", got.bin_count, want.bin_count);
        if (got.pad !== want.pad)
            report_mismatch("pad", got.pad, want.pad);
    endtask

    // Offer one transfer after a random gap and hold it until the block takes it.
    task automatic send_record(rlqs_op_t op, logic bank, logic [LEN_W-1:0] len,
                               logic [QFIX_W-1:0] qfix, logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, idx, qfix, len};
        s_axis_tuser  <= {bank, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_record(op, bank, len, qfix, idx);
    endtask

    // Result side: check each transfer, then pick the next ready level.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                check_result(rlqs_result_t'(m_axis_tdata));
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run when nothing moves on either side for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb failed");
        $finish;
    end

    task automatic test_empty_banks();
        send_record(OP_SUMMARY,  1'b0, '0, '0, '0);
        send_record(OP_SUMMARY,  1'b1, '0, '0, '0);
        send_record(OP_LEN_BIN,  1'b0, '0, '0, '0);
        send_record(OP_QUAL_BIN, 1'b1, '0, '0, '0);
    endtask

    task automatic test_record_extremes();
        send_record(OP_ACC, 1'b1, '0,      10'h000, '0);
        send_record(OP_ACC, 1'b1, LEN_MAX, 10'h3FF, '1);
        send_record(OP_ACC, 1'b1, 32'd4094, 10'h01F, '0);
        send_record(OP_ACC, 1'b0, 32'd4095, 10'h3F0, '0);
        send_record(OP_ACC, 1'b0, 32'd4096, 10'h3EF, '0);
        // fraction bits drop: quality below one counts as zero
        send_record(OP_ACC, 1'b0, 32'd1,    10'h00F, '0);
        send_record(OP_SUMMARY,  1'b0, '0, '0, '0);
        send_record(OP_SUMMARY,  1'b1, '0, '0, '0);
        send_record(OP_LEN_BIN,  1'b1, '0, '0, 12'd0);
        send_record(OP_LEN_BIN,  1'b1, '0, '0, 12'd4094);
        send_record(OP_LEN_BIN,  1'b0, '0, '0, 12'd4095);
        send_record(OP_LEN_BIN,  1'b1, '0, '0, 12'd4095);
        send_record(OP_QUAL_BIN, 1'b0, '0, '0, 12'd62);
        send_record(OP_QUAL_BIN, 1'b0, '0, '0, 12'd63);
        send_record(OP_QUAL_BIN, 1'b1, '0, '0, 12'd0);
        send_record(OP_QUAL_BIN, 1'b1, '0, '0, 12'd1);
        send_record(OP_QUAL_BIN, 1'b0, '0, '0, 12'd64);
        send_record(OP_QUAL_BIN, 1'b1, '0, '0, 12'd4095);
    endtask

    task automatic test_random_mix(int count);
        rlqs_op_t          op;
        logic              bank;
        logic [LEN_W-1:0]  len;
        logic [QFIX_W-1:0] qfix;
        logic [IDX_W-1:0]  idx;
        int                pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                op = OP_ACC;
            else if (pick < 75)
                op = OP_SUMMARY;
            else if (pick < 88)
                op = OP_LEN_BIN;
            else
                op = OP_QUAL_BIN;
            bank = 1'($urandom_range(1));
            case ($urandom_range(3))
                0:       len = $urandom;
                1:       len = $urandom_range(LENGTH_BINS_DEF + 16, LENGTH_BINS_DEF - 16);
                default: len = $urandom_range(300);
            endcase
            qfix = QFIX_W'($urandom_range(1023));
            // aim many bin reads at bins that were just hit
            case ($urandom_range(2))
                0:       idx = IDX_W'($urandom_range(4095));
                1:       idx = (op == OP_QUAL_BIN) ? IDX_W'($urandom_range(70)) :
                               IDX_W'($urandom_range(300));
                default: idx = (op == OP_QUAL_BIN) ? last_quality : last_length_bin;
            endcase
            send_record(op, bank, len, qfix, idx);
        end
    endtask

    task automatic test_backpressure();
        hold_off_cycles = HOLD_CYCLES;
        for (int i = 0; i < 60; i++)
        begin
            if (i % 3 == 0)
                send_record(OP_SUMMARY, i[0], '0, '0, '0);
            else
                send_record(OP_QUAL_BIN, i[0], '0, '0, IDX_W'(i));
        end
    endtask

    task automatic test_long_reads();
        repeat (LONG_RECORDS)
            send_record(OP_ACC, 1'b0, LEN_MAX, QFIX_W'($urandom_range(1023)), '0);
        send_record(OP_SUMMARY, 1'b0, '0, '0, '0);
        send_record(OP_LEN_BIN, 1'b0, '0, '0, 12'd4095);
        send_record(OP_SUMMARY, 1'b1, '0, '0, '0);
    endtask

    initial
    begin
        clear_stats();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_banks();
        test_record_extremes();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_mix(450);
        send_idle_pct  = 79;
        recv_stall_pct = 0;
        test_random_mix(450);
        send_idle_pct  = 0;
        recv_stall_pct = 79;
        test_random_mix(450);
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        test_random_mix(450);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_backpressure();
        test_long_reads();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
